### rtl/assert_macros.svh
// Assertion macros used by the back end (utf8d_back) of the UTF-8 character decoder.
// Each macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// When the trigger holds, the consequence must hold in the same cycle.
`define ASSERT_IMPLIES(label, trig, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cons)) \
        else $error(msg);

// When the trigger holds, the consequence must hold in the following cycle.
`define ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

### rtl/utf8d_pkg.sv
// Package of the UTF-8 character decoder: item types, constants and decode tables.
// Used by utf8d_front, utf8d_back and utf8_char_decoder; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package utf8d_pkg;

    localparam logic [15:0] C_REPLACEMENT  = 16'hFFFD;
    localparam logic [8:0]  C_TAIL_PATTERN = 9'h02A;
    localparam logic [13:0] C_SURR_TOP     = 14'h001B;
    localparam logic [24:0] C_MAX_CODE     = 25'h000FFFF;
    localparam logic [5:0]  C_TAIL_MASK    = 6'h3F;
    localparam logic [2:0]  C_WINDOW       = 3'd4;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned COUNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [7:0] lead_byte;
        logic [7:0] second_byte;
        logic [7:0] third_byte;
        logic [7:0] fourth_byte;
        logic [2:0] bytes_available;
        logic       end_known;
    } t_in_item;

    typedef struct packed {
        logic [15:0] code_point;
        logic [2:0]  bytes_consumed;
        logic        invalid;
    } t_out_item;

    // Classified item handed from the front to the back.
    typedef struct packed {
        logic [2:0] len;
        logic [2:0] wanted;
        logic [7:0] win0;
        logic [7:0] win1;
        logic [7:0] win2;
        logic [7:0] win3;
    } t_cls_item;

    function automatic logic [2:0] f_len_class(input logic [4:0] top);
        logic [2:0] len;
        len = 3'd0;
        case (top[4:2])
            3'd0, 3'd1, 3'd2, 3'd3: len = 3'd1;
            3'd6:                   len = 3'd2;
            3'd7: begin
                case (top[1:0])
                    2'd0, 2'd1: len = 3'd3;
                    2'd2:       len = 3'd4;
                    default:    len = 3'd0;
                endcase
            end
            default:                len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic logic [6:0] f_lead_mask(input logic [2:0] len);
        logic [6:0] m;
        case (len)
            3'd1:    m = 7'h7F;
            3'd2:    m = 7'h1F;
            3'd3:    m = 7'h0F;
            3'd4:    m = 7'h07;
            default: m = 7'h00;
        endcase
        return m;
    endfunction

    function automatic logic [24:0] f_min_code(input logic [2:0] len);
        logic [24:0] m;
        case (len)
            3'd1:    m = 25'h0000000;
            3'd2:    m = 25'h0000080;
            3'd3:    m = 25'h0000800;
            3'd4:    m = 25'h0010000;
            default: m = 25'h0400000;
        endcase
        return m;
    endfunction

    function automatic logic [4:0] f_code_shift(input logic [2:0] len);
        logic [4:0] s;
        case (len)
            3'd1:    s = 5'd18;
            3'd2:    s = 5'd12;
            3'd3:    s = 5'd6;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    function automatic logic [2:0] f_err_shift(input logic [2:0] len);
        logic [2:0] s;
        case (len)
            3'd1:    s = 3'd6;
            3'd2:    s = 3'd4;
            3'd3:    s = 3'd2;
            default: s = 3'd0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

### rtl/utf8_char_decoder.sv
// Top level of the UTF-8 character decoder: front classifier and back decoder
// joined by a two-entry queue. Uses utf8d_pkg, utf8d_front and utf8d_back.
`timescale 1ns / 1ps
`default_nettype none

// Decodes one UTF-8 character per item from a four-byte window and returns
// its 16-bit code point, the number of bytes to advance and an error flag;
// any error yields 0xFFFD. Both sides are queues: the block sustains one item
// per clock while results are popped as they come, and a pushed item is
// written into the classified-item queue of the front, then passes through
// the decode logic into the result queue of the back. Each queue holds two
// items, but a full queue takes no new item in the cycle it hands one on, so
// at full rate a result that is held back turns into a hold on the input
// once both queues have filled.
module utf8_char_decoder (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   push,
    output logic                  full,
    input  utf8d_pkg::t_in_item   i_in_item,
    output logic                  empty,
    input  wire                   pop,
    output utf8d_pkg::t_out_item  o_out_item
);

    utf8d_pkg::t_cls_item w_cls;
    logic                 w_cls_valid;
    logic                 w_cls_take;

    utf8d_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_item  (i_in_item),
        .o_valid (w_cls_valid),
        .i_take  (w_cls_take),
        .o_cls   (w_cls)
    );

    utf8d_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_cls_valid),
        .o_take  (w_cls_take),
        .i_cls   (w_cls),
        .o_empty (empty),
        .i_pop   (pop),
        .o_item  (o_out_item)
    );

endmodule

`default_nettype wire

### rtl/utf8d_front.sv
// Front end of the UTF-8 decoder: accepts input items, classifies the lead
// byte and masks the window, then queues classified items. Uses utf8d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module utf8d_front (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_push,
    output logic                  o_full,
    input  utf8d_pkg::t_in_item   i_item,
    output logic                  o_valid,
    input  wire                   i_take,
    output utf8d_pkg::t_cls_item  o_cls
);

    utf8d_pkg::t_cls_item                 w_cls;
    logic [2:0]                           w_avail;
    logic                                 w_wr;
    logic                                 w_rd;

    utf8d_pkg::t_cls_item                 r_q [utf8d_pkg::QUEUE_DEPTH];
    logic [utf8d_pkg::COUNT_W-1:0]        r_count;
    logic [utf8d_pkg::COUNT_W-1:0]        n_count;
    logic [utf8d_pkg::PTR_W-1:0]          r_wr_ptr;
    logic [utf8d_pkg::PTR_W-1:0]          r_rd_ptr;

    always_comb begin
        w_cls.len    = utf8d_pkg::f_len_class(i_item.lead_byte[7:3]);
        w_cls.wanted = (w_cls.len == 3'd0) ? 3'd1 : w_cls.len;
        // Without a known end the text is assumed to hold the whole sequence.
        if (i_item.end_known) begin
            w_avail = (i_item.bytes_available > utf8d_pkg::C_WINDOW) ?
                      utf8d_pkg::C_WINDOW : i_item.bytes_available;
        end else begin
            w_avail = w_cls.wanted;
        end
        w_cls.win0 = (w_avail > 3'd0) ? i_item.lead_byte   : 8'h00;
        w_cls.win1 = (w_avail > 3'd1) ? i_item.second_byte : 8'h00;
        w_cls.win2 = (w_avail > 3'd2) ? i_item.third_byte  : 8'h00;
        w_cls.win3 = (w_avail > 3'd3) ? i_item.fourth_byte : 8'h00;
    end

    assign o_full  = (r_count == utf8d_pkg::COUNT_W'(utf8d_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cls   = r_q[r_rd_ptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_take && o_valid;

    always_comb begin
        n_count = r_count;
        if (w_wr && !w_rd) begin
            n_count = r_count + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            r_count <= n_count;
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wr_ptr] <= w_cls;
        end
    end

endmodule

`default_nettype wire

### rtl/utf8d_back.sv
// Back end of the UTF-8 decoder: assembles the code point, collects the error
// word and queues results. Uses utf8d_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module utf8d_back (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    output logic                  o_take,
    input  utf8d_pkg::t_cls_item  i_cls,
    output logic                  o_empty,
    input  wire                   i_pop,
    output utf8d_pkg::t_out_item  o_item
);

    logic [6:0]                           w_lead;
    logic [24:0]                          w_raw;
    logic [24:0]                          w_code;
    logic [8:0]                           w_err_raw;
    logic [8:0]                           w_err;
    logic [2:0]                           w_nonzero;
    utf8d_pkg::t_out_item                 w_res;
    logic                                 w_rd;

    utf8d_pkg::t_out_item                 r_q [utf8d_pkg::QUEUE_DEPTH];
    logic [utf8d_pkg::COUNT_W-1:0]        r_count;
    logic [utf8d_pkg::COUNT_W-1:0]        n_count;
    logic [utf8d_pkg::PTR_W-1:0]          r_wr_ptr;
    logic [utf8d_pkg::PTR_W-1:0]          r_rd_ptr;

    always_comb begin
        w_lead = i_cls.win0[6:0] & utf8d_pkg::f_lead_mask(i_cls.len);
        // Assemble as a full four-byte form, then drop the unused low bits.
        w_raw  = {w_lead, 18'd0}
               | {7'd0, i_cls.win1[5:0] & utf8d_pkg::C_TAIL_MASK,
                        i_cls.win2[5:0] & utf8d_pkg::C_TAIL_MASK,
                        i_cls.win3[5:0] & utf8d_pkg::C_TAIL_MASK};
        w_code = w_raw >> utf8d_pkg::f_code_shift(i_cls.len);

        w_err_raw = {(w_code > utf8d_pkg::C_MAX_CODE),
                     (w_code[24:11] == utf8d_pkg::C_SURR_TOP),
                     (w_code < utf8d_pkg::f_min_code(i_cls.len)),
                     i_cls.win1[7:6], i_cls.win2[7:6], i_cls.win3[7:6]};
        // Each tail must read 10b; shorter forms shift out the unused checks.
        w_err = (w_err_raw ^ utf8d_pkg::C_TAIL_PATTERN) >> utf8d_pkg::f_err_shift(i_cls.len);

        w_nonzero = 3'(i_cls.win0 != 8'h00) + 3'(i_cls.win1 != 8'h00)
                  + 3'(i_cls.win2 != 8'h00) + 3'(i_cls.win3 != 8'h00);

        if (w_err != 9'd0) begin
            w_res.code_point     = utf8d_pkg::C_REPLACEMENT;
            w_res.bytes_consumed = (w_nonzero < i_cls.wanted) ? w_nonzero : i_cls.wanted;
            w_res.invalid        = 1'b1;
        end else begin
            w_res.code_point     = w_code[15:0];
            w_res.bytes_consumed = i_cls.wanted;
            w_res.invalid        = 1'b0;
        end
    end

    assign o_take  = i_valid && (r_count != utf8d_pkg::COUNT_W'(utf8d_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_q[r_rd_ptr];
    assign w_rd    = i_pop && !o_empty;

    always_comb begin
        n_count = r_count;
        if (o_take && !w_rd) begin
            n_count = r_count + 1'b1;
        end else if (w_rd && !o_take) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            r_count <= n_count;
            if (o_take) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_q[r_wr_ptr] <= w_res;
        end
    end

    `ASSERT_ALWAYS(a_count_bound,
        r_count <= utf8d_pkg::COUNT_W'(utf8d_pkg::QUEUE_DEPTH), "result queue overflow")
    `ASSERT_IMPLIES(a_invalid_repl, !o_empty && o_item.invalid,
        o_item.code_point == utf8d_pkg::C_REPLACEMENT, "invalid item without replacement")
    `ASSERT_IMPLIES(a_consumed_bound, !o_empty,
        o_item.bytes_consumed <= utf8d_pkg::C_WINDOW, "item consumes more than the window")
    `ASSERT_NEXT(a_take_lands, o_take && !w_rd,
        !o_empty, "taken item did not reach the result queue")

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for the UTF-8 character decoder (utf8_char_decoder).
// Depends on utf8d_pkg for the item types and decode constants and on the RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam logic [31:0] ERR_OVERLONG  = 32'h040;
    localparam logic [31:0] ERR_SURROGATE = 32'h080;
    localparam logic [31:0] ERR_RANGE     = 32'h100;
    localparam int unsigned MAX_REPORTS   = 10;
    localparam int unsigned IDLE_PCT      = 36;
    localparam int unsigned HOLD_CYCLES   = 60;
    localparam int unsigned DRAIN_CYCLES  = 10;

    class decode_scoreboard;
        utf8d_pkg::t_out_item expected_q[$];
        int unsigned          mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Works out the character, advance count and error flag for one window.
        function utf8d_pkg::t_out_item decode_window(utf8d_pkg::t_in_item it);
            logic [7:0]           raw [4];
            logic [7:0]           win [4];
            logic [4:0]           top;
            int unsigned          len;
            int unsigned          wanted;
            int unsigned          avail;
            int unsigned          nonzero;
            int unsigned          cshift;
            int unsigned          eshift;
            logic [31:0]          lmask;
            logic [31:0]          floor_cp;
            logic [31:0]          cp;
            logic [31:0]          err;
            utf8d_pkg::t_out_item res;

            raw[0] = it.lead_byte;
            raw[1] = it.second_byte;
            raw[2] = it.third_byte;
            raw[3] = it.fourth_byte;

            top = it.lead_byte[7:3];
            if (top < 5'd16)       len = 1;
            else if (top < 5'd24)  len = 0;
            else if (top < 5'd28)  len = 2;
            else if (top < 5'd30)  len = 3;
            else if (top == 5'd30) len = 4;
            else                   len = 0;

            case (len)
                1: begin
                    lmask = 32'h7F; floor_cp = 32'h0;      cshift = 18; eshift = 6;
                end
                2: begin
                    lmask = 32'h1F; floor_cp = 32'h80;     cshift = 12; eshift = 4;
                end
                3: begin
                    lmask = 32'h0F; floor_cp = 32'h800;    cshift = 6;  eshift = 2;
                end
                4: begin
                    lmask = 32'h07; floor_cp = 32'h10000;  cshift = 0;  eshift = 0;
                end
                default: begin
                    lmask = 32'h00; floor_cp = 32'h400000; cshift = 0;  eshift = 0;
                end
            endcase

            wanted = (len == 0) ? 1 : len;
            if (it.end_known)
                avail = (it.bytes_available > 3'd4) ? 4 : 32'(it.bytes_available);
            else
                avail = wanted;

            for (int i = 0; i < 4; i++)
                win[i] = (i < avail) ? raw[i] : 8'h00;

            cp = (32'(win[0]) & lmask) << 18;
            cp |= (32'(win[1]) & 32'(utf8d_pkg::C_TAIL_MASK)) << 12;
            cp |= (32'(win[2]) & 32'(utf8d_pkg::C_TAIL_MASK)) << 6;
            cp |= 32'(win[3]) & 32'(utf8d_pkg::C_TAIL_MASK);
            cp = cp >> cshift;

            err = (cp < floor_cp) ? ERR_OVERLONG : 32'h0;
            err |= ((cp >> 11) == 32'(utf8d_pkg::C_SURR_TOP)) ? ERR_SURROGATE : 32'h0;
            err |= (cp > 32'(utf8d_pkg::C_MAX_CODE)) ? ERR_RANGE : 32'h0;
            // Top two bits of each tail byte land in the error word; the
            // pattern then cancels them when they read as continuation bits.
            err |= (32'(win[1]) & 32'hC0) >> 2;
            err |= (32'(win[2]) & 32'hC0) >> 4;
            err |= 32'(win[3]) >> 6;
            err ^= 32'(utf8d_pkg::C_TAIL_PATTERN);
            err = err >> eshift;

            if (err != 32'h0) begin
                nonzero = 0;
                for (int i = 0; i < 4; i++)
                    nonzero += (win[i] != 8'h00) ? 1 : 0;
                if (nonzero < wanted)
                    wanted = nonzero;
                res.code_point = utf8d_pkg::C_REPLACEMENT;
                res.invalid    = 1'b1;
            end else begin
                res.code_point = cp[15:0];
                res.invalid    = 1'b0;
            end
            res.bytes_consumed = wanted[2:0];
            return res;
        endfunction

        function void note_input(utf8d_pkg::t_in_item it);
            expected_q.push_back(decode_window(it));
        endfunction

        function void check_result(utf8d_pkg::t_out_item got);
            utf8d_pkg::t_out_item want;

            if (expected_q.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("%0t: unexpected result cp=%h n=%0d inv=%0b", $realtime,
                             got.code_point, got.bytes_consumed, got.invalid);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            if (got.code_point !== want.code_point ||
                got.bytes_consumed !== want.bytes_consumed ||
                got.invalid !== want.invalid) begin
                if (mismatches < MAX_REPORTS)
                    $display("%0t: mismatch exp cp=%h n=%0d inv=%0b got cp=%h n=%0d inv=%0b",
                             $realtime, want.code_point, want.bytes_consumed, want.invalid,
                             got.code_point, got.bytes_consumed, got.invalid);
                mismatches++;
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function bit failed();
            return (mismatches != 0) || (expected_q.size() != 0);
        endfunction
    endclass

    logic                 i_clk     = 1'b0;
    logic                 i_rst_n   = 1'b0;
    logic                 push      = 1'b0;
    logic                 pop       = 1'b0;
    utf8d_pkg::t_in_item  i_in_item = '0;
    logic                 full;
    logic                 empty;
    utf8d_pkg::t_out_item o_out_item;

    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;
    int unsigned hold_left  = 0;

    decode_scoreboard sb = new();

    utf8_char_decoder u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_item  (i_in_item),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (o_out_item)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    // Both handshakes are sampled on the values that the block saw at the edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full)
                sb.note_input(i_in_item);
            if (pop && !empty)
                sb.check_result(o_out_item);
        end
    end

    // Result side: random stalls, plus a long hold-off when one is requested.
    initial begin
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                pop <= 1'b0;
                hold_left--;
            end else if (rx_idle_on && $urandom_range(99) < IDLE_PCT) begin
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    task automatic send_char(input utf8d_pkg::t_in_item it);
        while (tx_idle_on && $urandom_range(99) < IDLE_PCT) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push      <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (full);
    endtask

    task automatic send_bytes(input logic [7:0] b0, input logic [7:0] b1,
                              input logic [7:0] b2, input logic [7:0] b3,
                              input logic [2:0] avail, input logic known);
        utf8d_pkg::t_in_item it;
        it.lead_byte       = b0;
        it.second_byte     = b1;
        it.third_byte      = b2;
        it.fourth_byte     = b3;
        it.bytes_available = avail;
        it.end_known       = known;
        send_char(it);
    endtask

    // Mostly well-formed sequences of random length and content, some with a
    // broken tail or a short end, and the rest plain noise.
    function automatic utf8d_pkg::t_in_item random_window();
        utf8d_pkg::t_in_item it;
        int unsigned         len;

        it.lead_byte       = 8'($urandom);
        it.second_byte     = 8'($urandom);
        it.third_byte      = 8'($urandom);
        it.fourth_byte     = 8'($urandom);
        it.bytes_available = 3'($urandom);
        it.end_known       = 1'($urandom);
        if ($urandom_range(99) < 65) begin
            len = $urandom_range(1, 4);
            case (len)
                1:       it.lead_byte = {1'b0, 7'($urandom)};
                2:       it.lead_byte = {3'b110, 5'($urandom)};
                3:       it.lead_byte = {4'b1110, 4'($urandom)};
                default: it.lead_byte = {5'b11110, 3'($urandom)};
            endcase
            it.second_byte = {2'b10, 6'($urandom)};
            it.third_byte  = {2'b10, 6'($urandom)};
            it.fourth_byte = {2'b10, 6'($urandom)};
            if ($urandom_range(9) == 0) begin
                case ($urandom_range(2))
                    0:       it.second_byte[7:6] = 2'($urandom);
                    1:       it.third_byte[7:6]  = 2'($urandom);
                    default: it.fourth_byte[7:6] = 2'($urandom);
                endcase
            end
            if (it.end_known && $urandom_range(3) != 0)
                it.bytes_available = 3'(len);
        end
        return it;
    endfunction

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // NUL, ASCII extremes and ASCII lead with junk after it.
        send_bytes(8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 1'b0);
        send_bytes(8'h41, 8'h00, 8'h00, 8'h00, 3'd0, 1'b0);
        send_bytes(8'h7F, 8'hFF, 8'hFF, 8'hFF, 3'd4, 1'b1);
        // Two-byte forms: smallest, largest, typical and overlong.
        send_bytes(8'hC2, 8'h80, 8'h00, 8'h00, 3'd0, 1'b0);
        send_bytes(8'hDF, 8'hBF, 8'h00, 8'h00, 3'd2, 1'b1);
        send_bytes(8'hC3, 8'hA9, 8'h41, 8'h41, 3'd4, 1'b1);
        send_bytes(8'hC0, 8'h80, 8'h00, 8'h00, 3'd0, 1'b0);
        send_bytes(8'hC1, 8'hBF, 8'h00, 8'h00, 3'd0, 1'b0);
        // Three-byte forms: smallest, largest, typical, surrogate, overlong,
        // broken continuation.
        send_bytes(8'hE0, 8'hA0, 8'h80, 8'h00, 3'd0, 1'b0);
        send_bytes(8'hEF, 8'hBF, 8'hBF, 8'hFF, 3'd3, 1'b1);
        send_bytes(8'hE2, 8'h82, 8'hAC, 8'h00, 3'd7, 1'b1);
        send_bytes(8'hED, 8'hA0, 8'h80, 8'h00, 3'd0, 1'b0);
        send_bytes(8'hE0, 8'h80, 8'h80, 8'h00, 3'd0, 1'b0);
        send_bytes(8'hE2, 8'h28, 8'hA1, 8'h00, 3'd0, 1'b0);
        // Four-byte forms always end in the replacement character.
        send_bytes(8'hF0, 8'h90, 8'h80, 8'h80, 3'd0, 1'b0);
        send_bytes(8'hF0, 8'h80, 8'h80, 8'h80, 3'd4, 1'b1);
        send_bytes(8'hF7, 8'hBF, 8'hBF, 8'hBF, 3'd5, 1'b1);
        // Bad lead bytes: continuation bytes and the 0xF8 and up range.
        send_bytes(8'h80, 8'h80, 8'h80, 8'h80, 3'd0, 1'b0);
        send_bytes(8'hBF, 8'h00, 8'h00, 8'h00, 3'd4, 1'b1);
        send_bytes(8'hF8, 8'h88, 8'h80, 8'h80, 3'd0, 1'b0);
        send_bytes(8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd4, 1'b1);
        // Short ends: truncated sequence and nothing available at all.
        send_bytes(8'hE2, 8'h82, 8'hAC, 8'h00, 3'd2, 1'b1);
        send_bytes(8'h41, 8'h42, 8'h43, 8'h44, 3'd0, 1'b1);
        send_bytes(8'hE2, 8'h82, 8'hAC, 8'h00, 3'd0, 1'b1);
        send_bytes(8'hC3, 8'hA9, 8'h00, 8'h00, 3'd1, 1'b1);

        // The receiver stops for a while; the sender keeps offering until the
        // queues fill and the block holds its input off.
        tx_idle_on = 1'b0;
        hold_left  = HOLD_CYCLES;
        repeat (20) send_char(random_window());
        tx_idle_on = 1'b1;

        repeat (130) send_char(random_window());
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        repeat (100) send_char(random_window());
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        repeat (125) send_char(random_window());
        push <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.failed())
            $display("tb_top: FAIL");
        else
            $display("tb_top: PASS");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/utf8d_pkg.sv
rtl/utf8d_front.sv
rtl/utf8d_back.sv
rtl/utf8_char_decoder.sv
tb/tb_top.sv
